@@ rtl/core/deq_pkg.sv @@
// shared constants, codes and types for the double-ended queue
package deq_pkg;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [1:0]            func_t;
	typedef logic [1:0]            status_t;

	localparam func_t OP_PUSH_BACK  = 2'd0;
	localparam func_t OP_PUSH_FRONT = 2'd1;
	localparam func_t OP_POP_BACK   = 2'd2;
	localparam func_t OP_POP_FRONT  = 2'd3;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam count_t DEPTH_CNT = count_t'(DEPTH);

	// one command per cycle, already gated by full, empty and the input stall
	typedef struct packed {
		logic add_back;
		logic add_front;
		logic drop_back;
		logic drop_front;
	} cmd_t;

endpackage

@@ rtl/core/deq_cell.sv @@
// one storage cell of the queue, shifting with its neighbors
module deq_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  deq_pkg::cmd_t cmd,
	input  deq_pkg::data_t push_value,
	input  logic          left_valid,
	input  deq_pkg::data_t left_data,
	input  logic          right_valid,
	input  deq_pkg::data_t right_data,
	output logic          valid,
	output deq_pkg::data_t data,
	output logic          last
);

	logic           valid_q;
	deq_pkg::data_t data_q;
	logic           fill_here;

	// the first free cell takes a push at the back
	assign fill_here = left_valid && !valid_q;
	assign last      = valid_q && !right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.add_front) begin
			valid_q <= left_valid;
		end else if (cmd.drop_front) begin
			valid_q <= right_valid;
		end else if (cmd.add_back && fill_here) begin
			valid_q <= 1'b1;
		end else if (cmd.drop_back && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_front) begin
			data_q <= left_data;
		end else if (cmd.drop_front) begin
			data_q <= right_data;
		end else if (cmd.add_back && fill_here) begin
			data_q <= push_value;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// double-ended queue built as a row of shifting cells
// the result word is offered in the cycle after the input word is taken
// throughput: one operation per cycle while the result side keeps up
// front ops shift the row of cells by one place; back ops fill the first free cell or clear the last one
// reset: queue empty, no result pending; cell data is left uninitialized
module double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic signed [31:0] push_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [4:0]  occupancy,
	output logic [1:0]  status
);

	localparam int unsigned N = deq_pkg::DEPTH;

	logic              accept;
	logic              full;
	logic              empty;
	deq_pkg::cmd_t     cmd;
	deq_pkg::status_t  status_d;
	deq_pkg::data_t    value_in;

	logic              out_valid_q;
	deq_pkg::status_t  status_q;
	deq_pkg::count_t   count_q;

	logic              cell_valid [N];
	deq_pkg::data_t    cell_data  [N];
	logic              cell_last  [N];
	deq_pkg::data_t    back_sel;

	// hold input while an unread result is blocked
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == deq_pkg::DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign value_in = deq_pkg::data_t'(push_value);

	always_comb begin
		cmd      = '0;
		status_d = deq_pkg::ST_DONE;
		case (func)
			deq_pkg::OP_PUSH_BACK: begin
				if (full) status_d = deq_pkg::ST_FULL;
				else      cmd.add_back = accept;
			end
			deq_pkg::OP_PUSH_FRONT: begin
				if (full) status_d = deq_pkg::ST_FULL;
				else      cmd.add_front = accept;
			end
			deq_pkg::OP_POP_BACK: begin
				if (empty) status_d = deq_pkg::ST_EMPTY;
				else       cmd.drop_back = accept;
			end
			deq_pkg::OP_POP_FRONT: begin
				if (empty) status_d = deq_pkg::ST_EMPTY;
				else       cmd.drop_front = accept;
			end
			default: begin
				cmd      = '0;
				status_d = deq_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= deq_pkg::ST_DONE;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.add_back || cmd.add_front) begin
				count_q <= count_q + deq_pkg::count_t'(1);
			end else if (cmd.drop_back || cmd.drop_front) begin
				count_q <= count_q - deq_pkg::count_t'(1);
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic           lv;
		deq_pkg::data_t ld;
		logic           rv;
		deq_pkg::data_t rd;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = value_in;
		end else begin : g_mid
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_inner
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.push_value  (value_in),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.data        (cell_data[i]),
			.last        (cell_last[i])
		);
	end

	// exactly one cell is flagged last when the queue holds anything
	always_comb begin
		back_sel = '0;
		for (int i = 0; i < N; i++) begin
			back_sel = back_sel | (cell_data[i] & {deq_pkg::DATA_WIDTH{cell_last[i]}});
		end
	end

	assign out_valid   = out_valid_q;
	assign front_value = cell_valid[0] ? cell_data[0] : '0;
	assign back_value  = back_sel;
	assign occupancy   = count_q;
	assign status      = status_q;

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == deq_pkg::ST_FULL) |-> (occupancy == deq_pkg::DEPTH_CNT))
		else $error("push refused while not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == deq_pkg::ST_EMPTY) |-> (occupancy == '0))
		else $error("pop refused while not empty");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		(occupancy == '0) |-> (front_value == '0 && back_value == '0))
		else $error("empty queue shows nonzero values");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(occupancy != '0) == cell_valid[0])
		else $error("count and head cell disagree");

endmodule
